[hdl/fwamm_pkg.sv]
// shared types and constants for the record queue with largest, smallest and mean queries
package fwamm_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned AMOUNT_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned REC_W    = ID_W + AMOUNT_W;
  localparam int unsigned IN_W     = ((CMD_W + ID_W + AMOUNT_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MAX  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MIN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MEAN = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_WAIT,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

[hdl/fifo_with_argmax_argmin_mean_top.sv]
// record queue with oldest-first pop, largest/smallest amount search and mean amount
// a request passes through EXEC and DONE; with a non-empty queue, pop adds POP_WAIT,
// largest/smallest add SCAN, a one-entry-per-cycle scan over the single-port record
// memory, and mean adds DIV, the one-bit-per-cycle divider
// one request is worked on at a time; the next is taken once its result is registered
// reset empties the queue at once; the record memory is not cleared
module fifo_with_argmax_argmin_mean_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // cmd[2:0], item_id[18:3], amount[50:19], zero fill
  input  logic [fwamm_pkg::IN_W-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status[1:0], result_id[17:2], result_value[49:18], fill_count from bit 50, zero fill
  output logic [((50 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = fwamm_pkg::AMOUNT_W + PTR_W;
  localparam int unsigned DCNT_W  = $clog2(SUM_W);
  localparam int unsigned OUT_BITS = fwamm_pkg::STATUS_W + fwamm_pkg::ID_W
                                   + fwamm_pkg::AMOUNT_W + CNT_W;
  localparam int unsigned OUT_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  fwamm_pkg::state_e state_q, state_d;

  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] held_q, held_d, scan_cnt_q, scan_cnt_d;
  logic [SUM_W-1:0] sum_q, sum_d, dq_q, dq_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [DCNT_W-1:0] div_cnt_q, div_cnt_d;

  logic [fwamm_pkg::CMD_W-1:0]    cmd_q, cmd_d;
  logic [fwamm_pkg::ID_W-1:0]     id_q, id_d;
  logic [fwamm_pkg::AMOUNT_W-1:0] amt_q, amt_d;

  logic [fwamm_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [fwamm_pkg::ID_W-1:0]     res_id_q, res_id_d;
  logic [fwamm_pkg::AMOUNT_W-1:0] res_val_q, res_val_d;

  logic                           m_valid_q, m_valid_d;
  logic [fwamm_pkg::STATUS_W-1:0] o_status_q, o_status_d;
  logic [fwamm_pkg::ID_W-1:0]     o_id_q, o_id_d;
  logic [fwamm_pkg::AMOUNT_W-1:0] o_val_q, o_val_d;
  logic [CNT_W-1:0]               o_fill_q, o_fill_d;

  logic [fwamm_pkg::REC_W-1:0] mem_q [DEPTH];
  logic [fwamm_pkg::REC_W-1:0] rd_data_q;
  logic                        rd_en, wr_en;
  logic [PTR_W-1:0]            rd_addr;

  logic                           s_fire, out_free, better;
  logic [fwamm_pkg::ID_W-1:0]     rd_id;
  logic [fwamm_pkg::AMOUNT_W-1:0] rd_amt;
  logic [CNT_W:0]                 trial;
  logic [CNT_W:0]                 trial_diff;
  logic                           qbit;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  assign s_axis_tready = (state_q == fwamm_pkg::ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign rd_id  = rd_data_q[fwamm_pkg::ID_W-1:0];
  assign rd_amt = rd_data_q[fwamm_pkg::REC_W-1:fwamm_pkg::ID_W];
  assign better = (cmd_q == fwamm_pkg::CMD_MAX) ? (rd_amt > res_val_q) : (rd_amt < res_val_q);

  assign trial      = {rem_q, dq_q[SUM_W-1]};
  assign trial_diff = trial - {1'b0, held_q};
  assign qbit       = (trial >= {1'b0, held_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fwamm_pkg::ST_IDLE: begin
        if (s_fire) state_d = fwamm_pkg::ST_EXEC;
      end
      fwamm_pkg::ST_EXEC: begin
        state_d = fwamm_pkg::ST_DONE;
        if (held_q != '0) begin
          case (cmd_q)
            fwamm_pkg::CMD_POP:  state_d = fwamm_pkg::ST_POP_WAIT;
            fwamm_pkg::CMD_MAX,
            fwamm_pkg::CMD_MIN:  state_d = fwamm_pkg::ST_SCAN;
            fwamm_pkg::CMD_MEAN: state_d = fwamm_pkg::ST_DIV;
            default:             state_d = fwamm_pkg::ST_DONE;
          endcase
        end
      end
      fwamm_pkg::ST_POP_WAIT: state_d = fwamm_pkg::ST_DONE;
      fwamm_pkg::ST_SCAN: begin
        if (scan_cnt_q == held_q - CNT_W'(1)) state_d = fwamm_pkg::ST_DONE;
      end
      fwamm_pkg::ST_DIV: begin
        if (div_cnt_q == '0) state_d = fwamm_pkg::ST_DONE;
      end
      fwamm_pkg::ST_DONE: begin
        if (out_free) state_d = fwamm_pkg::ST_IDLE;
      end
      default: state_d = fwamm_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    held_d       = held_q;
    sum_d        = sum_q;
    rd_ptr_d     = rd_ptr_q;
    scan_cnt_d   = scan_cnt_q;
    dq_d         = dq_q;
    rem_d        = rem_q;
    div_cnt_d    = div_cnt_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    amt_d        = amt_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_val_d    = res_val_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    o_status_d   = o_status_q;
    o_id_d       = o_id_q;
    o_val_d      = o_val_q;
    o_fill_d     = o_fill_q;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    wr_en        = 1'b0;

    case (state_q)
      fwamm_pkg::ST_IDLE: begin
        if (s_fire) begin
          cmd_d = s_axis_tdata[2:0];
          id_d  = s_axis_tdata[18:3];
          amt_d = s_axis_tdata[50:19];
        end
      end
      fwamm_pkg::ST_EXEC: begin
        res_status_d = fwamm_pkg::STATUS_OK;
        res_id_d     = '0;
        res_val_d    = '0;
        if (cmd_q == fwamm_pkg::CMD_PUSH) begin
          if (held_q == FULL_CNT) begin
            res_status_d = fwamm_pkg::STATUS_FULL;
          end else begin
            wr_en  = 1'b1;
            tail_d = next_slot(tail_q);
            held_d = held_q + CNT_W'(1);
            sum_d  = sum_q + SUM_W'(amt_q);
          end
        end else if (cmd_q inside {fwamm_pkg::CMD_POP, fwamm_pkg::CMD_MAX,
                                   fwamm_pkg::CMD_MIN, fwamm_pkg::CMD_MEAN}) begin
          if (held_q == '0) begin
            res_status_d = fwamm_pkg::STATUS_EMPTY;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = head_q;
            rd_ptr_d   = next_slot(head_q);
            scan_cnt_d = '0;
            dq_d       = sum_q;
            rem_d      = '0;
            div_cnt_d  = DCNT_W'(SUM_W - 1);
          end
        end
      end
      fwamm_pkg::ST_POP_WAIT: begin
        res_id_d  = rd_id;
        res_val_d = rd_amt;
        head_d    = next_slot(head_q);
        held_d    = held_q - CNT_W'(1);
        sum_d     = sum_q - SUM_W'(rd_amt);
      end
      fwamm_pkg::ST_SCAN: begin
        rd_en      = 1'b1;
        rd_addr    = rd_ptr_q;
        rd_ptr_d   = next_slot(rd_ptr_q);
        scan_cnt_d = scan_cnt_q + CNT_W'(1);
        if (scan_cnt_q == '0 || better) begin
          res_id_d  = rd_id;
          res_val_d = rd_amt;
        end
      end
      fwamm_pkg::ST_DIV: begin
        rem_d     = qbit ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        dq_d      = {dq_q[SUM_W-2:0], qbit};
        div_cnt_d = div_cnt_q - DCNT_W'(1);
        if (div_cnt_q == '0) res_val_d = dq_d[fwamm_pkg::AMOUNT_W-1:0];
      end
      fwamm_pkg::ST_DONE: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          o_status_d = res_status_q;
          o_id_d     = res_id_q;
          o_val_d    = res_val_q;
          o_fill_d   = held_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fwamm_pkg::ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      held_q    <= '0;
      sum_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      held_q    <= held_d;
      sum_q     <= sum_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q     <= rd_ptr_d;
    scan_cnt_q   <= scan_cnt_d;
    dq_q         <= dq_d;
    rem_q        <= rem_d;
    div_cnt_q    <= div_cnt_d;
    cmd_q        <= cmd_d;
    id_q         <= id_d;
    amt_q        <= amt_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_val_q    <= res_val_d;
    o_status_q   <= o_status_d;
    o_id_q       <= o_id_d;
    o_val_q      <= o_val_d;
    o_fill_q     <= o_fill_d;
  end

  // record memory, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[tail_q] <= {amt_q, id_q};
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({o_fill_q, o_val_q, o_id_q, o_status_q});

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= FULL_CNT)
    else $error("held count beyond depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0 || held_q == FULL_CNT) |-> (head_q == tail_q))
    else $error("pointers disagree with held count");

  a_sum_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> (sum_q == '0))
    else $error("running sum not zero on empty queue");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fwamm_pkg::ST_SCAN) |-> (scan_cnt_q < held_q))
    else $error("scan ran past stored records");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && o_status_q != fwamm_pkg::STATUS_OK) |-> (o_id_q == '0 && o_val_q == '0))
    else $error("error result carries data");

endmodule

[tb/tb.sv]
// testbench for the record queue: random and directed requests checked against a queue predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CMD_W    = fwamm_pkg::CMD_W;
  localparam int unsigned ID_W     = fwamm_pkg::ID_W;
  localparam int unsigned AMOUNT_W = fwamm_pkg::AMOUNT_W;
  localparam int unsigned STATUS_W = fwamm_pkg::STATUS_W;
  localparam int unsigned IN_W     = fwamm_pkg::IN_W;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W  = ((50 + FILL_W + 7) / 8) * 8;
  localparam int unsigned N_REQ  = 1800;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     id;
    logic [AMOUNT_W-1:0] amount;
    bit                  drain;
  } ledger_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     rid;
    logic [AMOUNT_W-1:0] rval;
    logic [FILL_W-1:0]   fill;
  } ledger_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  fifo_with_argmax_argmin_mean_top #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // predictor state
  logic [ID_W-1:0]     rec_id [DEPTH];
  logic [AMOUNT_W-1:0] rec_amt [DEPTH];
  int unsigned         rec_head = 0;
  int unsigned         rec_tail = 0;
  int unsigned         rec_count = 0;
  logic [35:0]         amount_total = '0;

  ledger_req_t   pending[$];
  ledger_reply_t replies_due[$];
  ledger_req_t   nxt_req;
  ledger_reply_t got, want;

  bit          req_taken = 1'b0;
  bit          rsp_taken = 1'b0;
  int unsigned tx_gap = 0, tx_quiet = 0;
  int unsigned rx_stall = 0, rx_quiet = 0;
  int unsigned fail_count = 0;
  int unsigned n_push = 0, n_full = 0, n_pop = 0, n_extreme = 0, n_mean = 0;
  int unsigned n_empty = 0, n_spare = 0, n_holdoff = 0, n_results = 0;

  function automatic ledger_reply_t ledger_apply(ledger_req_t rq);
    ledger_reply_t rs;
    int unsigned p, best;
    rs.status = fwamm_pkg::STATUS_OK;
    rs.rid = '0;
    rs.rval = '0;
    case (rq.cmd)
      fwamm_pkg::CMD_PUSH: begin
        if (rec_count >= DEPTH) begin
          rs.status = fwamm_pkg::STATUS_FULL;
        end else begin
          rec_id[rec_tail] = rq.id;
          rec_amt[rec_tail] = rq.amount;
          rec_tail = (rec_tail + 1) % DEPTH;
          rec_count++;
          amount_total += 36'(rq.amount);
        end
      end
      fwamm_pkg::CMD_POP, fwamm_pkg::CMD_MAX, fwamm_pkg::CMD_MIN, fwamm_pkg::CMD_MEAN: begin
        if (rec_count == 0) begin
          rs.status = fwamm_pkg::STATUS_EMPTY;
        end else if (rq.cmd == fwamm_pkg::CMD_POP) begin
          rs.rid = rec_id[rec_head];
          rs.rval = rec_amt[rec_head];
          amount_total -= 36'(rec_amt[rec_head]);
          rec_head = (rec_head + 1) % DEPTH;
          rec_count--;
        end else if (rq.cmd == fwamm_pkg::CMD_MEAN) begin
          rs.rval = AMOUNT_W'(amount_total / 36'(rec_count));
        end else begin
          // oldest to newest, strict compare keeps the oldest on ties
          p = rec_head;
          best = rec_head;
          for (int k = 1; k < rec_count; k++) begin
            p = (p + 1) % DEPTH;
            if (rq.cmd == fwamm_pkg::CMD_MAX ? rec_amt[p] > rec_amt[best]
                                             : rec_amt[p] < rec_amt[best])
              best = p;
          end
          rs.rid = rec_id[best];
          rs.rval = rec_amt[best];
        end
      end
      default: ;
    endcase
    rs.fill = FILL_W'(rec_count);
    return rs;
  endfunction

  // mostly short idles, a few long ones, and quiet stretches with none
  function automatic int unsigned idle_len(ref int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) quiet = $urandom_range(20, 80);
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic add_req(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                         logic [AMOUNT_W-1:0] amount, bit drain);
    ledger_req_t rq;
    rq.cmd = cmd;
    rq.id = id;
    rq.amount = amount;
    rq.drain = drain;
    pending.push_back(rq);
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        if (tx_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          tx_gap--;
        end else if (pending.size() > 0 && !(pending[0].drain && replies_due.size() > 0)) begin
          nxt_req = pending.pop_front();
          s_axis_tdata <= IN_W'({nxt_req.amount, nxt_req.id, nxt_req.cmd});
          s_axis_tvalid <= 1'b1;
          tx_gap = idle_len(tx_quiet);
          if (nxt_req.drain) n_holdoff++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rsp_taken || $urandom_range(0, 7) == 0) rx_stall = idle_len(rx_quiet);
      end
    end
  end

  // monitor: check results, then predict for the request taken at this edge
  always @(posedge clk_i) begin
    rsp_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    req_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rsp_taken) begin
      got.status = m_axis_tdata[1:0];
      got.rid = m_axis_tdata[17:2];
      got.rval = m_axis_tdata[49:18];
      got.fill = m_axis_tdata[50 +: FILL_W];
      n_results++;
      if (replies_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with none pending: status %0d id %h value %h fill %0d",
                   $realtime, got.status, got.rid, got.rval, got.fill);
      end else begin
        want = replies_due.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch: status %0d/%0d id %h/%h value %h/%h fill %0d/%0d (exp/got)",
                     $realtime, want.status, got.status, want.rid, got.rid,
                     want.rval, got.rval, want.fill, got.fill);
        end
      end
    end
    if (req_taken) begin
      nxt_req.cmd = s_axis_tdata[2:0];
      nxt_req.id = s_axis_tdata[18:3];
      nxt_req.amount = s_axis_tdata[50:19];
      nxt_req.drain = 1'b0;
      want = ledger_apply(nxt_req);
      replies_due.push_back(want);
      if (want.status == fwamm_pkg::STATUS_EMPTY) n_empty++;
      case (nxt_req.cmd)
        fwamm_pkg::CMD_PUSH: begin
          n_push++;
          if (want.status == fwamm_pkg::STATUS_FULL) n_full++;
        end
        fwamm_pkg::CMD_POP: n_pop++;
        fwamm_pkg::CMD_MAX, fwamm_pkg::CMD_MIN: n_extreme++;
        fwamm_pkg::CMD_MEAN: n_mean++;
        default: n_spare++;
      endcase
    end
  end

  initial begin
    int unsigned counted, phase_left, push_pct, r;
    int unsigned gen_fill;
    logic [CMD_W-1:0] cmd;
    logic [AMOUNT_W-1:0] amt, last_amt;
    bit drain;

    // empty queue, unused codes
    add_req(fwamm_pkg::CMD_POP, '0, '0, 1'b0);
    add_req(fwamm_pkg::CMD_MAX, '0, '0, 1'b0);
    add_req(fwamm_pkg::CMD_MIN, '0, '0, 1'b0);
    add_req(fwamm_pkg::CMD_MEAN, '0, '0, 1'b0);
    add_req(CMD_SPARE_LO, '1, '1, 1'b0);
    add_req(CMD_SPARE_HI, '0, '0, 1'b0);
    // fill with equal maximum amounts: ties, largest sum, push on full
    for (int i = 0; i < DEPTH; i++)
      add_req(fwamm_pkg::CMD_PUSH,
              i == 0 ? 16'h0000 : i == DEPTH - 1 ? 16'hffff : ID_W'(i * 16'h1111),
              '1, 1'b0);
    add_req(fwamm_pkg::CMD_PUSH, 16'h5a5a, '0, 1'b0);
    add_req(fwamm_pkg::CMD_MEAN, '0, '0, 1'b0);
    add_req(fwamm_pkg::CMD_MAX, '0, '0, 1'b0);
    add_req(fwamm_pkg::CMD_MIN, '0, '0, 1'b0);
    add_req(CMD_SPARE_MID, '0, '0, 1'b0);

    gen_fill = DEPTH;
    counted = 0;
    phase_left = 0;
    push_pct = 50;
    last_amt = '1;
    drain = 1'b1;
    while (counted < N_REQ) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0: push_pct = 70;
          1: push_pct = 25;
          default: push_pct = 45;
        endcase
      end
      phase_left--;
      if ($urandom_range(0, 99) < 3) begin
        add_req(fwamm_pkg::CMD_MEAN + CMD_W'($urandom_range(1, 3)), ID_W'($urandom),
                $urandom, 1'b0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
          cmd = fwamm_pkg::CMD_PUSH;
          if (gen_fill < DEPTH) gen_fill++;
        end else if (r < push_pct + (100 - push_pct) * 6 / 10) begin
          cmd = fwamm_pkg::CMD_POP;
          if (gen_fill > 0) gen_fill--;
        end else begin
          case ($urandom_range(0, 2))
            0: cmd = fwamm_pkg::CMD_MAX;
            1: cmd = fwamm_pkg::CMD_MIN;
            default: cmd = fwamm_pkg::CMD_MEAN;
          endcase
        end
        case ($urandom_range(0, 7))
          0: amt = '0;
          1: amt = '1;
          2: amt = last_amt;
          3: amt = $urandom_range(0, 255);
          default: amt = $urandom;
        endcase
        last_amt = amt;
        add_req(cmd, ID_W'($urandom_range(0, 65535)), amt, drain);
        drain = ($urandom_range(0, 199) == 0);
        counted++;
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (replies_due.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    fail_count += replies_due.size();

    $display("run covered %0d requests: %0d pushes (%0d on a full queue), %0d pops,",
             n_results, n_push, n_full, n_pop);
    $display("%0d largest/smallest, %0d mean, %0d refused on an empty queue, %0d unused codes,",
             n_extreme, n_mean, n_empty, n_spare);
    $display("%0d hold-offs until drained, %0d failures", n_holdoff, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
